@@ hdl/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg: shared types, constants and arithmetic helpers
// Payload words, queue control word, register indexes and modulo-26 helpers
// used by the front, back and top level of the Hill block transform.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int unsigned MAX_ORDER_DEFAULT = 9;
	localparam int unsigned KEY_STRIDE        = 9;
	localparam int unsigned KEY_WORDS         = 7;
	localparam int unsigned KEY_WORD_W        = 60;
	localparam int unsigned ENTRY_W           = 5;
	localparam int unsigned KEY_BITS          = KEY_WORDS * KEY_WORD_W;
	localparam int unsigned LETTER_W          = 5;
	localparam int unsigned PROD_W            = 10;
	localparam int unsigned ORDER_W           = 4;
	localparam int unsigned CFG_INDEX_W       = 4;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam logic [LETTER_W-1:0] MODULUS   = 5'd26;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_SIZE = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_FIRST  = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LAST   = 4'd7;

	typedef struct packed {
		logic [LETTER_W-1:0] letter;
		logic                start_of_message;
	} in_word_t;

	typedef struct packed {
		logic [LETTER_W-1:0] out_letter;
		logic                last_of_block;
	} out_word_t;

	// control half of one queue entry
	typedef struct packed {
		logic               clear;
		logic               emit;
		logic [ORDER_W-1:0] order;
	} hcb_ctrl_t;

	// clamp the block size register into 2..max_n
	function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] bs,
		input int unsigned max_n);
		logic [ORDER_W-1:0] n;
		n = bs;
		if (bs < 4'd2) begin
			n = 4'd2;
		end else if (int'(bs) > int'(max_n)) begin
			n = ORDER_W'(max_n);
		end
		return n;
	endfunction

	// fold a 5-bit value into 0..25
	function automatic logic [LETTER_W-1:0] red5(input logic [LETTER_W-1:0] x);
		return (x >= MODULUS) ? x - MODULUS : x;
	endfunction

	// x mod 26 by reciprocal: quotient 78/2048 never overshoots, one fix-up
	function automatic logic [LETTER_W-1:0] mod26(input logic [PROD_W-1:0] x);
		logic [16:0]       t;
		logic [5:0]        q;
		logic [PROD_W-1:0] r;
		t = 17'(x) * 17'd78;
		q = t[16:11];
		r = x - PROD_W'(q) * PROD_W'(MODULUS);
		if (r >= PROD_W'(MODULUS)) begin
			r = r - PROD_W'(MODULUS);
		end
		return r[LETTER_W-1:0];
	endfunction

endpackage

@@ hdl/hcb_queue.sv @@
// ----------------------------------------------------------------------------
// hcb_queue: short register queue between front and back
// Holds classified letters with their column products until the back pops.
// ----------------------------------------------------------------------------
module hcb_queue #(
	parameter int unsigned DATA_W = 8,
	parameter int unsigned DEPTH  = hcb_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output logic [DATA_W-1:0] head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][DATA_W-1:0] mem_q;
	logic [PTR_W-1:0]             wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]             cnt_q;

	function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ hdl/hcb_front.sv @@
// ----------------------------------------------------------------------------
// hcb_front: letter intake and classification
// Tracks the group position, picks the key row and forms one product per
// column; flags group start and group completion for the back.
// ----------------------------------------------------------------------------
module hcb_front #(
	parameter int unsigned MAX_ORDER = hcb_pkg::MAX_ORDER_DEFAULT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       in_valid,
	output logic                                       in_stall,
	input  hcb_pkg::in_word_t                          in_data,
	input  logic [hcb_pkg::ORDER_W-1:0]                block_size,
	input  logic [hcb_pkg::KEY_BITS-1:0]               key_flat,
	input  logic                                       q_full,
	output logic                                       push,
	output hcb_pkg::hcb_ctrl_t                         ctrl,
	output logic [MAX_ORDER-1:0][hcb_pkg::PROD_W-1:0]  prods
);

	localparam int unsigned POS_W = $clog2(MAX_ORDER + 1);
	localparam int unsigned ROW_W = $clog2(MAX_ORDER);

	logic [MAX_ORDER-1:0][MAX_ORDER-1:0][hcb_pkg::ENTRY_W-1:0] key_rows;
	logic [hcb_pkg::ORDER_W-1:0]  order;
	logic [POS_W-1:0]             pos_q, pos_eff, pos_next, n_p, row_sel;
	logic [hcb_pkg::LETTER_W-1:0] letter_r;
	logic                         emit;

	always_comb begin
		for (int r = 0; r < MAX_ORDER; r++) begin
			for (int j = 0; j < MAX_ORDER; j++) begin
				key_rows[r][j] = key_flat[(r * hcb_pkg::KEY_STRIDE + j) * hcb_pkg::ENTRY_W
					+: hcb_pkg::ENTRY_W];
			end
		end
	end

	always_comb begin
		order    = hcb_pkg::eff_order(block_size, MAX_ORDER);
		n_p      = POS_W'(order);
		pos_eff  = in_data.start_of_message ? '0 : pos_q;
		// clip the row when the block size shrank under a partial group
		row_sel  = (pos_eff >= n_p) ? n_p - 1'b1 : pos_eff;
		pos_next = pos_eff + 1'b1;
		emit     = (pos_next >= n_p);
		letter_r = hcb_pkg::red5(in_data.letter);
		for (int j = 0; j < MAX_ORDER; j++) begin
			// columns past the current order hold their sums
			if (j < int'(order)) begin
				prods[j] = hcb_pkg::PROD_W'(letter_r) *
					hcb_pkg::PROD_W'(hcb_pkg::red5(key_rows[row_sel[ROW_W-1:0]][j]));
			end else begin
				prods[j] = '0;
			end
		end
	end

	assign in_stall   = q_full;
	assign push       = in_valid && !q_full;
	assign ctrl.clear = in_data.start_of_message;
	assign ctrl.emit  = emit;
	assign ctrl.order = order;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (push) begin
			pos_q <= emit ? '0 : pos_next;
		end
	end

endmodule

@@ hdl/hcb_back.sv @@
// ----------------------------------------------------------------------------
// hcb_back: column accumulation and block output
// Folds products into the running column sums and shifts out each finished
// block through an output buffer while the next group accumulates.
// ----------------------------------------------------------------------------
module hcb_back #(
	parameter int unsigned MAX_ORDER = hcb_pkg::MAX_ORDER_DEFAULT
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_valid,
	input  hcb_pkg::hcb_ctrl_t                         ctrl,
	input  logic [MAX_ORDER-1:0][hcb_pkg::PROD_W-1:0]  prods,
	output logic                                       pop,
	output logic                                       out_valid,
	input  logic                                       out_stall,
	output hcb_pkg::out_word_t                         out_data
);

	localparam int unsigned POS_W = $clog2(MAX_ORDER + 1);

	logic [MAX_ORDER-1:0][hcb_pkg::LETTER_W-1:0] sums_q, sum_new, obuf_q;
	logic [POS_W-1:0]                            cnt_q;
	logic                                        out_take, can_load, load;

	assign out_valid = (cnt_q != '0);
	assign out_take  = out_valid && !out_stall;
	// a new block may enter the buffer as the last word of the old one leaves
	assign can_load  = (cnt_q == '0) || ((cnt_q == POS_W'(1)) && out_take);
	assign pop       = q_valid && (!ctrl.emit || can_load);
	assign load      = pop && ctrl.emit;

	always_comb begin
		for (int j = 0; j < MAX_ORDER; j++) begin
			sum_new[j] = hcb_pkg::mod26(prods[j] +
				hcb_pkg::PROD_W'(ctrl.clear ? '0 : sums_q[j]));
		end
	end

	assign out_data.out_letter    = obuf_q[0];
	assign out_data.last_of_block = (cnt_q == POS_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				sums_q <= ctrl.emit ? '0 : sum_new;
			end
			if (load) begin
				cnt_q <= POS_W'(ctrl.order);
			end else if (out_take) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			obuf_q <= sum_new;
		end else if (out_take) begin
			for (int j = 0; j < MAX_ORDER - 1; j++) begin
				obuf_q[j] <= obuf_q[j + 1];
			end
		end
	end

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (cnt_q == '0) || ((cnt_q == POS_W'(1)) && out_take))
		else $error("block loaded over words not yet delivered");

	a_load_count: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid && (cnt_q >= POS_W'(2)) && (cnt_q <= POS_W'(MAX_ORDER)))
		else $error("output count out of range after block load");

	a_sums_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (sums_q == '0))
		else $error("column sums not cleared after block");

endmodule

@@ hdl/hill_cipher_block_transform.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_block_transform: Hill cipher row-vector-times-key block
// Accumulates letter * key row into per-column sums mod 26 and emits each
// finished block of cipher letters, last letter marked.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------
//  in      | in_valid / in_stall  | in_data: letter, start_of_message
//  out     | out_valid / out_stall| out_data: out_letter, last_of_block
//  cfg     | cfg_valid / cfg_ready| cfg_index (0 size, 1..7 key words)
//
//  One letter per cycle is accepted while in_stall is low; a letter is
//  registered in the queue, then folded into the column sums; a finished
//  block is loaded into the output buffer and leaves one word per cycle
//  while out_stall is low. The single output buffer sets the pace: n
//  letters in, n words out. in_stall rises only while the two-entry queue
//  is full; the back holds a completing letter in the queue while the
//  previous block drains. Reset clears sums, position, queue, output count,
//  key and size registers (block size resets to 2). cfg_ready is always high.
//
module hill_cipher_block_transform #(
	parameter int unsigned MAX_ORDER = hcb_pkg::MAX_ORDER_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  hcb_pkg::in_word_t               in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output hcb_pkg::out_word_t              out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [hcb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [hcb_pkg::KEY_WORD_W-1:0]  cfg_data
);

	localparam int unsigned CTRL_W  = $bits(hcb_pkg::hcb_ctrl_t);
	localparam int unsigned ENTRY_W = CTRL_W + MAX_ORDER * hcb_pkg::PROD_W;

	logic [hcb_pkg::ORDER_W-1:0]                              block_size_q;
	logic [hcb_pkg::KEY_WORDS-1:0][hcb_pkg::KEY_WORD_W-1:0]  key_q;
	logic [hcb_pkg::CFG_INDEX_W-1:0]                          key_sel;

	hcb_pkg::hcb_ctrl_t                        f_ctrl, b_ctrl;
	logic [MAX_ORDER-1:0][hcb_pkg::PROD_W-1:0] f_prods, b_prods;
	logic [ENTRY_W-1:0]                        q_head;
	logic                                      push, pop, q_full, q_valid;

	// cfg registers: always ready; user must write only while idle (unchecked)
	assign cfg_ready = 1'b1;
	assign key_sel   = cfg_index - hcb_pkg::CFG_KEY_FIRST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= hcb_pkg::ORDER_W'(2);
			key_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == hcb_pkg::CFG_BLOCK_SIZE) begin
				block_size_q <= cfg_data[hcb_pkg::ORDER_W-1:0];
			end else if ((cfg_index >= hcb_pkg::CFG_KEY_FIRST) &&
				(cfg_index <= hcb_pkg::CFG_KEY_LAST)) begin
				key_q[key_sel[2:0]] <= cfg_data;
			end
			// drop writes beyond the register list
		end
	end

	// front: take letters, pick key row, form column products
	hcb_front #(.MAX_ORDER(MAX_ORDER)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.block_size (block_size_q),
		.key_flat   (key_q),
		.q_full     (q_full),
		.push       (push),
		.ctrl       (f_ctrl),
		.prods      (f_prods)
	);

	// queue: registers the products and decouples the two stall domains
	hcb_queue #(.DATA_W(ENTRY_W), .DEPTH(hcb_pkg::QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({f_ctrl, f_prods}),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (q_head)
	);

	assign b_ctrl  = q_head[ENTRY_W-1 -: CTRL_W];
	assign b_prods = q_head[ENTRY_W-CTRL_W-1:0];

	// back: accumulate sums, shift out finished blocks
	hcb_back #(.MAX_ORDER(MAX_ORDER)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.ctrl      (b_ctrl),
		.prods     (b_prods),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for hill_cipher_block_transform
// Feeds letter words through the block under several key and block size
// settings and idling mixes, predicts cipher words from a behavioral Hill
// accumulator kept here or from typed-in rows, compares each output word in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned LIMIT_CYCLES = 200000;
	localparam int unsigned QUIET_CYCLES = 8;     // pipeline drain before a register write
	localparam int unsigned HOLD_CYCLES  = 80;    // long receiver hold-off
	localparam int unsigned PHASE_ITEMS  = 112;
	localparam int unsigned PRINT_CAP    = 100;
	localparam int unsigned ORDER_MAX    = hcb_pkg::MAX_ORDER_DEFAULT;

	// register indexes past the end of the list; the block must ignore them
	localparam logic [hcb_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LOW = hcb_pkg::CFG_KEY_LAST + 4'd1;
	localparam logic [hcb_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_TOP = '1;

	typedef enum logic {ROW_LETTER, ROW_CONFIG} row_kind_t;

	// one line of the directed stimulus
	typedef struct packed {
		row_kind_t                        kind;
		logic [hcb_pkg::LETTER_W-1:0]     letter;
		logic                             som;
		logic [hcb_pkg::CFG_INDEX_W-1:0]  idx;
		logic [hcb_pkg::KEY_WORD_W-1:0]   data;
		logic                             known;       // expected words typed in below
		logic [hcb_pkg::ORDER_W-1:0]      exp_cnt;
		logic [hcb_pkg::LETTER_W-1:0]     exp_letter;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            in_valid = 1'b0;
	logic                            in_stall;
	hcb_pkg::in_word_t               in_data = '0;
	logic                            out_valid;
	logic                            out_stall = 1'b0;
	hcb_pkg::out_word_t              out_data;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [hcb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [hcb_pkg::KEY_WORD_W-1:0]  cfg_data = '0;

	// idling mix, long hold-off and run bookkeeping
	int unsigned tx_pct = 0;
	int unsigned rx_pct = 0;
	bit          pressure_armed = 1'b0;
	logic        long_hold = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	// behavioral copy of the block's registers and running group
	logic [hcb_pkg::ORDER_W-1:0]    size_reg;
	logic [hcb_pkg::KEY_WORD_W-1:0] key_reg [hcb_pkg::KEY_WORDS];
	int unsigned                    col_sum [hcb_pkg::KEY_STRIDE];
	int unsigned                    grp_pos;

	hcb_pkg::out_word_t cipher_expected [$];
	stim_row_t          stim_rows [$];

	hill_cipher_block_transform i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	// append one word to the tail of the expected list
	function automatic void add_expected(input hcb_pkg::out_word_t w);
		cipher_expected = {cipher_expected, w};
	endfunction

	function automatic void clear_group();
		for (int unsigned j = 0; j < hcb_pkg::KEY_STRIDE; j++) begin
			col_sum[j] = 0;
		end
		grp_pos = 0;
	endfunction

	function automatic void hill_reset();
		size_reg = 4'd2;
		for (int unsigned i = 0; i < hcb_pkg::KEY_WORDS; i++) begin
			key_reg[i] = '0;
		end
		clear_group();
	endfunction

	// clamp the size register into the supported key orders
	function automatic int unsigned hill_order();
		int unsigned n;
		n = 32'(size_reg);
		if (n < 2) n = 2;
		if (n > ORDER_MAX) n = ORDER_MAX;
		return n;
	endfunction

	// key[row][col], packed twelve five-bit entries per register
	function automatic int unsigned key_at(input int unsigned row, input int unsigned col);
		int unsigned flat;
		flat = row * hcb_pkg::KEY_STRIDE + col;
		return 32'((key_reg[flat / 12] >> ((flat % 12) * hcb_pkg::ENTRY_W)) & 60'h1f);
	endfunction

	function automatic void hill_configure(input logic [hcb_pkg::CFG_INDEX_W-1:0] idx,
		input logic [hcb_pkg::KEY_WORD_W-1:0] d);
		if (idx == hcb_pkg::CFG_BLOCK_SIZE) begin
			size_reg = d[hcb_pkg::ORDER_W-1:0];
		end else if (idx >= hcb_pkg::CFG_KEY_FIRST && idx <= hcb_pkg::CFG_KEY_LAST) begin
			key_reg[idx - hcb_pkg::CFG_KEY_FIRST] = d;
		end
	endfunction

	// fold one letter into the column sums; queue the block when it completes
	function automatic void hill_accumulate(input hcb_pkg::in_word_t w, input bit record);
		int unsigned        n, ltr, row, modv;
		hcb_pkg::out_word_t o;
		modv = 32'(hcb_pkg::MODULUS);
		n    = hill_order();
		ltr  = 32'(w.letter) % modv;
		if (w.start_of_message) clear_group();
		row = (grp_pos >= n) ? n - 1 : grp_pos;
		for (int unsigned j = 0; j < n; j++) begin
			col_sum[j] = (col_sum[j] + ltr * (key_at(row, j) % modv)) % modv;
		end
		grp_pos++;
		if (grp_pos >= n) begin
			for (int unsigned j = 0; j < n; j++) begin
				o.out_letter    = col_sum[j][hcb_pkg::LETTER_W-1:0];
				o.last_of_block = (j + 1 == n);
				if (record) add_expected(o);
			end
			clear_group();
		end
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatch_count < PRINT_CAP) begin
			$display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
		end
		mismatch_count++;
	endtask

	// compare every accepted output word with the oldest expected word
	always @(posedge clk) begin
		hcb_pkg::out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (cipher_expected.size() == 0) begin
				report_mismatch("word with nothing pending", int'(out_data.out_letter), -1);
			end else begin
				want = cipher_expected.pop_front();
				if (out_data.out_letter != want.out_letter)
					report_mismatch("out_letter", int'(out_data.out_letter),
						int'(want.out_letter));
				if (out_data.last_of_block != want.last_of_block)
					report_mismatch("last_of_block", int'(out_data.last_of_block),
						int'(want.last_of_block));
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// random stall per the current mix, forced high during the long hold-off
	always @(posedge clk) begin
		out_stall <= long_hold || (rx_pct != 0 && $urandom_range(99) < rx_pct);
	end

	// hold off the output long enough for the block to back up into in_stall
	initial begin : hold_off
		wait (pressure_armed);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	// ---------------------------------------------------------------- sender

	// offer one letter word, hold it until taken, then predict it
	task automatic send_letter(input logic [hcb_pkg::LETTER_W-1:0] ltr, input logic som,
		input bit record);
		hcb_pkg::in_word_t w;
		w.letter           = ltr;
		w.start_of_message = som;
		while (tx_pct != 0 && $urandom_range(99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		hill_accumulate(w, record);
	endtask

	// drop valid, drain every expected word, then let the pipeline settle
	task automatic settle();
		in_valid <= 1'b0;
		while (cipher_expected.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// write one register, then leave the port idle
	task automatic write_register(input logic [hcb_pkg::CFG_INDEX_W-1:0] idx,
		input logic [hcb_pkg::KEY_WORD_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		hill_configure(idx, d);
		@(posedge clk);
	endtask

	function automatic stim_row_t letter_row(input logic [hcb_pkg::LETTER_W-1:0] ltr,
		input logic som);
		stim_row_t r;
		r        = '0;
		r.kind   = ROW_LETTER;
		r.letter = ltr;
		r.som    = som;
		return r;
	endfunction

	function automatic stim_row_t known_row(input logic [hcb_pkg::LETTER_W-1:0] ltr,
		input logic som, input logic [hcb_pkg::ORDER_W-1:0] cnt,
		input logic [hcb_pkg::LETTER_W-1:0] el);
		stim_row_t r;
		r            = letter_row(ltr, som);
		r.known      = 1'b1;
		r.exp_cnt    = cnt;
		r.exp_letter = el;
		return r;
	endfunction

	function automatic stim_row_t config_row(input logic [hcb_pkg::CFG_INDEX_W-1:0] idx,
		input logic [hcb_pkg::KEY_WORD_W-1:0] d);
		stim_row_t r;
		r      = '0;
		r.kind = ROW_CONFIG;
		r.idx  = idx;
		r.data = d;
		return r;
	endfunction

	// ---------------------------------------------------------------- sequence

	initial begin : main_seq
		logic [hcb_pkg::LETTER_W-1:0] ltr;
		logic [hcb_pkg::ORDER_W-1:0]  size_pick;
		hcb_pkg::out_word_t           typed;

		hill_reset();
		stim_rows = '{
			// after reset the key is all zero: every block comes out as zeros
			letter_row(5'd31, 1'b1),
			known_row(5'd25, 1'b0, 4'd2, 5'd0),
			letter_row(5'd0, 1'b0),
			known_row(5'd26, 1'b0, 4'd2, 5'd0),
			// order 3, mixed key with entries above 25 in the second word
			config_row(hcb_pkg::CFG_BLOCK_SIZE, 60'd3),
			config_row(hcb_pkg::CFG_KEY_FIRST, 60'h5A5_A5A5_A5A5_A5A5),
			config_row(hcb_pkg::CFG_KEY_FIRST + 4'd1, '1),
			letter_row(5'd7, 1'b1),
			letter_row(5'd31, 1'b0),
			letter_row(5'd25, 1'b0),
			// start flag in the middle of a group throws the partial sums away
			letter_row(5'd4, 1'b0),
			letter_row(5'd9, 1'b1),
			letter_row(5'd0, 1'b0),
			letter_row(5'd13, 1'b0),
			// largest order, every key entry at its top code
			config_row(hcb_pkg::CFG_BLOCK_SIZE, 60'd9),
			config_row(hcb_pkg::CFG_KEY_FIRST, '1),
			config_row(hcb_pkg::CFG_KEY_FIRST + 4'd1, '1),
			config_row(hcb_pkg::CFG_KEY_FIRST + 4'd2, '1),
			config_row(hcb_pkg::CFG_KEY_FIRST + 4'd3, '1),
			config_row(hcb_pkg::CFG_KEY_FIRST + 4'd4, '1),
			config_row(hcb_pkg::CFG_KEY_FIRST + 4'd5, '1),
			config_row(hcb_pkg::CFG_KEY_LAST, '1),
			letter_row(5'd25, 1'b0), letter_row(5'd25, 1'b0), letter_row(5'd25, 1'b0),
			letter_row(5'd25, 1'b0), letter_row(5'd25, 1'b0), letter_row(5'd25, 1'b0),
			letter_row(5'd25, 1'b0), letter_row(5'd25, 1'b0), letter_row(5'd25, 1'b0),
			// leave a partial group, then shrink the order under it
			letter_row(5'd3, 1'b0),
			letter_row(5'd5, 1'b0),
			letter_row(5'd8, 1'b0),
			letter_row(5'd30, 1'b0),
			config_row(hcb_pkg::CFG_BLOCK_SIZE, 60'd3),
			letter_row(5'd12, 1'b0),
			// size below range acts as 2; indexes past the list are dropped
			config_row(hcb_pkg::CFG_BLOCK_SIZE, 60'd0),
			config_row(CFG_UNUSED_LOW, '1),
			config_row(CFG_UNUSED_TOP, '1),
			letter_row(5'd1, 1'b0),
			letter_row(5'd2, 1'b0)
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (stim_rows[r]) begin
			if (stim_rows[r].kind == ROW_CONFIG) begin
				settle();
				write_register(stim_rows[r].idx, stim_rows[r].data);
			end else begin
				send_letter(stim_rows[r].letter, stim_rows[r].som, !stim_rows[r].known);
				if (stim_rows[r].known) begin
					for (int unsigned j = 0; j < stim_rows[r].exp_cnt; j++) begin
						typed.out_letter    = stim_rows[r].exp_letter;
						typed.last_of_block = (j + 1 == stim_rows[r].exp_cnt);
						add_expected(typed);
					end
				end
			end
		end

		// random phases: no idling, sender gaps, receiver stalls, both
		for (int unsigned phase = 0; phase < 4; phase++) begin
			settle();
			case (phase)
				0: begin
					tx_pct = 0;
					rx_pct <= 0;
					size_pick = hcb_pkg::ORDER_W'($urandom_range(2, ORDER_MAX));
				end
				1: begin
					tx_pct = 50;
					rx_pct <= 0;
					size_pick = '1;           // above range: acts as the largest order
				end
				2: begin
					tx_pct = 0;
					rx_pct <= 50;
					size_pick = 4'd1;         // below range: acts as order 2
				end
				default: begin
					tx_pct = 22;
					rx_pct <= 22;
					size_pick = hcb_pkg::ORDER_W'($urandom_range(0, 15));
				end
			endcase
			write_register(hcb_pkg::CFG_BLOCK_SIZE, hcb_pkg::KEY_WORD_W'(size_pick));
			for (int unsigned k = 0; k < hcb_pkg::KEY_WORDS; k++) begin
				write_register(hcb_pkg::CFG_KEY_FIRST + hcb_pkg::CFG_INDEX_W'(k),
					hcb_pkg::KEY_WORD_W'({$urandom, $urandom}));
			end
			// partial groups carry across the register writes on purpose
			for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
				if (phase == 0 && i == 20) pressure_armed = 1'b1;
				ltr = ($urandom_range(9) == 0)
					? hcb_pkg::LETTER_W'($urandom_range(26, 31))
					: hcb_pkg::LETTER_W'($urandom_range(25));
				send_letter(ltr, $urandom_range(19) == 0, 1'b1);
			end
		end

		settle();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
